>>> rtl/stepseq_pkg.sv
// ----------------------------------------------------------------------------
// stepseq_pkg
// Types and constants shared by the clock-divided step sequencer.
// ----------------------------------------------------------------------------
package stepseq_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int STEP_W      = 8;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int LEN_W       = 9;
  localparam int MODE_W      = 3;
  localparam int DIV_W       = 8;
  localparam int DLEN_W      = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    DIR_UP   = 3'd0,
    DIR_DOWN = 3'd1,
    DIR_HOLD = 3'd2,
    DIR_WALK = 3'd3,
    DIR_JUMP = 3'd4
  } dir_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LEN  = 2'd0,
    CFG_DIR_MODE = 2'd1,
    CFG_CLK_DIV  = 2'd2,
    CFG_DLY_LEN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                       operation;
    logic                       trigger_high;
    logic                       position_valid;
    logic [FRAC_W-1:0]          position;
    logic                       random_direction;
    logic [FRAC_W-1:0]          random_fraction;
    logic [STEP_W-1:0]          entry_index;
    logic signed [SAMPLE_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [STEP_W-1:0]          current_step;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  seq_len;
    logic [MODE_W-1:0] dir_mode;
    logic [DIV_W-1:0]  clk_div;
  } step_cfg_t;

endpackage

>>> rtl/step_sequencer_clock_divided.sv
// ----------------------------------------------------------------------------
// step_sequencer_clock_divided
// Clock-divided step sequencer: step table lookup followed by a delay line.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data (in_item_t)
//   out      output     out_valid / out_ready  out_data (out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. A sample item's
// accepting edge updates the step and reads the table; a later edge, once the
// output is free, reads delay memory into the output register. Table writes
// give no result. Reset marks the step table and delay line empty, so no
// clearing pass. A stalled output holds one item in the output register and
// one in the table-read stage before in_ready drops; cfg_ready is always high.
// ----------------------------------------------------------------------------
module step_sequencer_clock_divided import stepseq_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]           sequence_length;
  logic [MODE_W-1:0]          direction_mode;
  logic [DIV_W-1:0]           clock_divisions;
  logic [DLEN_W-1:0]          delay_length;

  step_cfg_t                  step_cfg;
  logic                       accept;
  logic                       sample_acc;
  logic                       table_wr;
  logic                       en_s1;
  logic                       en_out;
  logic                       push;
  logic [STEP_W-1:0]          step_next;
  logic signed [SAMPLE_W-1:0] table_data;
  logic signed [SAMPLE_W-1:0] dly_sample;

  logic                       s1_valid;
  logic [STEP_W-1:0]          s1_step;
  logic                       o_valid;
  logic [STEP_W-1:0]          o_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_length <= LEN_W'(16);
      direction_mode  <= DIR_UP;
      clock_divisions <= DIV_W'(1);
      delay_length    <= DLEN_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEQ_LEN:  sequence_length <= cfg_data[LEN_W-1:0];
        CFG_DIR_MODE: direction_mode  <= cfg_data[MODE_W-1:0];
        CFG_CLK_DIV:  clock_divisions <= cfg_data[DIV_W-1:0];
        CFG_DLY_LEN:  delay_length    <= cfg_data[DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_cfg = '{seq_len: sequence_length, dir_mode: direction_mode,
                      clk_div: clock_divisions};

  assign en_out     = !o_valid || out_ready;
  assign en_s1      = !s1_valid || en_out;
  assign in_ready   = en_s1;
  assign accept     = in_valid && in_ready;
  assign sample_acc = accept && (op_t'(in_data.operation) == OP_SAMPLE);
  assign table_wr   = accept && (op_t'(in_data.operation) == OP_WRITE);
  assign push       = en_out && s1_valid;

  stepseq_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (sample_acc),
    .item      (in_data),
    .cfg       (step_cfg),
    .step_next (step_next)
  );

  stepseq_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (table_wr),
    .wr_addr (in_data.entry_index),
    .wr_data (in_data.entry_value),
    .rd_en   (en_s1),
    .rd_addr (step_next),
    .rd_data (table_data)
  );

  stepseq_delay #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (table_data),
    .dly_len   (delay_length),
    .sample    (dly_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid <= sample_acc;
      end
      if (en_out) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_step <= step_next;
    end
    if (push) begin
      o_step <= s1_step;
    end
  end

  assign out_valid = o_valid;
  assign out_data  = '{sample_out: dly_sample, current_step: o_step};

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en_s1) |=> (s1_valid && $stable(s1_step)))
    else $error("table-read stage lost its item during a stall");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && o_valid))
    else $error("input stalled with a free stage");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(s1_valid))
    else $error("result appeared without an item in the table-read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    table_wr |=> !s1_valid)
    else $error("table write entered the result pipeline");
`endif

endmodule

>>> rtl/stepseq_step.sv
// ----------------------------------------------------------------------------
// stepseq_step
// Trigger edge counter and step index update for one sample item.
// ----------------------------------------------------------------------------
module stepseq_step import stepseq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  in_item_t          item,
  input  step_cfg_t         cfg,
  output logic [STEP_W-1:0] step_next
);

  logic [STEP_W-1:0]        step_index;
  logic [DIV_W-1:0]         edge_count;
  logic                     previous_trigger;

  logic [LEN_W-1:0]         len;
  logic [DIV_W-1:0]         cnt;
  logic                     fire;
  logic [FRAC_W-1:0]        frac;
  logic [FRAC_W+LEN_W-1:0]  prod;
  logic [STEP_W-1:0]        scaled;
  logic [LEN_W-1:0]         inc;
  logic [STEP_W-1:0]        up_step;
  logic [STEP_W-1:0]        down_step;

  always_comb begin
    if (cfg.seq_len == '0) begin
      len = LEN_W'(1);
    end else if (cfg.seq_len > LEN_W'(TABLE_DEPTH)) begin
      len = LEN_W'(TABLE_DEPTH);
    end else begin
      len = cfg.seq_len;
    end
  end

  assign cnt  = (item.trigger_high && !previous_trigger) ? edge_count + DIV_W'(1) : edge_count;
  assign fire = (cnt >= cfg.clk_div);

  // position and jump share the one scaler: frac * len, integer part only
  assign frac   = item.position_valid ? item.position : item.random_fraction;
  assign prod   = (FRAC_W+LEN_W)'(frac) * (FRAC_W+LEN_W)'(len);
  assign scaled = prod[FRAC_W +: STEP_W];

  assign inc       = {1'b0, step_index} + LEN_W'(1);
  assign up_step   = (inc >= len) ? '0 : inc[STEP_W-1:0];
  assign down_step = (step_index == '0 || {1'b0, step_index} >= len) ?
                     STEP_W'(len - LEN_W'(1)) : step_index - STEP_W'(1);

  always_comb begin
    step_next = step_index;
    if (fire) begin
      if (item.position_valid) begin
        step_next = scaled;
      end else begin
        case (dir_mode_t'(cfg.dir_mode))
          DIR_UP:   step_next = up_step;
          DIR_DOWN: step_next = down_step;
          DIR_WALK: step_next = item.random_direction ? up_step : down_step;
          DIR_JUMP: step_next = scaled;
          default:  step_next = step_index;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index       <= '0;
      edge_count       <= '0;
      previous_trigger <= 1'b0;
    end else if (advance) begin
      step_index       <= step_next;
      edge_count       <= fire ? '0 : cnt;
      previous_trigger <= item.trigger_high;
    end
  end

endmodule

>>> rtl/stepseq_table.sv
// ----------------------------------------------------------------------------
// stepseq_table
// Step table memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stepseq_table import stepseq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [STEP_W-1:0]          wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [STEP_W-1:0]          rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     written;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvalid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

>>> rtl/stepseq_delay.sv
// ----------------------------------------------------------------------------
// stepseq_delay
// Circular delay line in one memory, with fill tracking in place of a clear.
// ----------------------------------------------------------------------------
module stepseq_delay import stepseq_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic signed [SAMPLE_W-1:0] push_data,
  input  logic [DLEN_W-1:0]          dly_len,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam int PTR_W = $clog2(DELAY_DEPTH);
  localparam int LIMIT = DELAY_DEPTH - 1;

  logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [PTR_W-1:0]           ptr;
  logic [PTR_W-1:0]           fill;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SAMPLE_W-1:0] hold_q;
  logic                       bypass_q;
  logic                       filled_q;

  logic [PTR_W-1:0]           d;
  logic [PTR_W:0]             wrap_sum;
  logic [PTR_W-1:0]           rd_addr;

  always_comb begin
    if (32'(dly_len) > 32'(LIMIT)) begin
      d = PTR_W'(LIMIT);
    end else begin
      d = PTR_W'(dly_len);
    end
  end

  assign wrap_sum = {1'b0, ptr} + (PTR_W+1)'(DELAY_DEPTH) - {1'b0, d};
  assign rd_addr  = (ptr >= d) ? ptr - d : wrap_sum[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[ptr] <= push_data;
      rdata_q  <= mem[rd_addr];
      hold_q   <= push_data;
    end
  end

  // fill counts pushes since reset, saturating; a slot is live once fill >= d
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      fill     <= '0;
      bypass_q <= 1'b0;
      filled_q <= 1'b0;
    end else if (push) begin
      ptr      <= (ptr == PTR_W'(LIMIT)) ? '0 : ptr + PTR_W'(1);
      fill     <= (fill == PTR_W'(LIMIT)) ? fill : fill + PTR_W'(1);
      bypass_q <= (d == '0);
      filled_q <= (fill >= d);
    end
  end

  assign sample = bypass_q ? hold_q : (filled_q ? rdata_q : '0);

endmodule
